// ----- design/lz4_block_decompressor_core_assert.svh -----
// assertion macros for the lz4 block decompressor
`ifndef LZ4_BLOCK_DECOMPRESSOR_CORE_ASSERT_SVH
`define LZ4_BLOCK_DECOMPRESSOR_CORE_ASSERT_SVH

`ifndef SYNTH
// general form: explicit clock and active-low reset
`define LZ4D_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// top-level form on clk_i and rst_ni
`define LZ4D_ASSERT_TOP(label, prop, msg) \
  `LZ4D_ASSERT(label, clk_i, rst_ni, prop, msg)
`else
`define LZ4D_ASSERT(label, clk, rstn, prop, msg)
`define LZ4D_ASSERT_TOP(label, prop, msg)
`endif

`endif

// ----- design/lz4d_pkg.sv -----
// shared types and constants of the lz4 block decompressor
package lz4d_pkg;

  localparam int unsigned CNT_W             = 17;
  localparam int unsigned BLOCK_BYTES_DEF   = 65536;
  localparam int unsigned MATCH_BASE_LEN    = 4;
  localparam logic [7:0]  LEN_EXT_CONTINUE  = 8'd255;
  localparam logic [3:0]  NIBBLE_EXTENDED   = 4'd15;

  typedef enum logic {
    OP_FEED = 1'b0,
    OP_TICK = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    ST_BYTE  = 2'd0,
    ST_DONE  = 2'd1,
    ST_ERROR = 2'd2,
    ST_BUSY  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    PH_TOKEN     = 3'd0,
    PH_LIT_EXT   = 3'd1,
    PH_LITERALS  = 3'd2,
    PH_OFF_LO    = 3'd3,
    PH_OFF_HI    = 3'd4,
    PH_MATCH_EXT = 3'd5,
    PH_COPY      = 3'd6,
    PH_ENDED     = 3'd7
  } phase_e;

  // one decoded result, before the copy byte is known
  typedef struct packed {
    logic             has_res;
    logic             is_copy;
    status_e          status;
    logic [7:0]       data;
    logic             done;
    logic [CNT_W-1:0] count;
  } dec_res_t;

endpackage

// ----- design/lz4d_history.sv -----
// history store: one write port, one registered read port
module lz4d_history
  import lz4d_pkg::*;
#(
  parameter int unsigned DEPTH = BLOCK_BYTES_DEF,
  parameter int unsigned AW    = $clog2(BLOCK_BYTES_DEF)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/lz4d_decoder.sv -----
// sequence parser: token, lengths, offset and copy bookkeeping
module lz4d_decoder
  import lz4d_pkg::*;
#(
  parameter int unsigned BLOCK_BYTES = BLOCK_BYTES_DEF,
  parameter int unsigned AW          = $clog2(BLOCK_BYTES_DEF)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  logic          opcode_i,
  input  logic [7:0]    comp_byte_i,
  input  logic          final_byte_i,
  output dec_res_t      res_o,
  output logic [AW-1:0] rd_addr_o,
  output logic [AW-1:0] wr_addr_o,
  output logic          lit_we_o
);

  localparam logic [CNT_W+1:0] LIMIT = (CNT_W+2)'(BLOCK_BYTES);

  phase_e           phase_q, phase_d;
  logic [CNT_W-1:0] wp_q, wp_d;
  logic [3:0]       mnib_q, mnib_d;
  logic [CNT_W-1:0] lit_left_q, lit_left_d;
  logic [CNT_W-1:0] match_left_q, match_left_d;
  logic [15:0]      off_q, off_d;

  logic [CNT_W:0]   lit_total;
  logic [CNT_W:0]   match_total;
  logic [CNT_W:0]   match_init;
  logic [15:0]      off_full;
  logic [3:0]       lit_nib;
  logic             fail;

  function automatic logic too_long(input logic [CNT_W-1:0] pos, input logic [CNT_W:0] len);
    logic [CNT_W+1:0] sum;
    sum = {2'b00, pos} + {1'b0, len};
    return sum > LIMIT;
  endfunction

  assign lit_total   = {1'b0, lit_left_q} + (CNT_W+1)'(comp_byte_i);
  assign match_total = {1'b0, match_left_q} + (CNT_W+1)'(comp_byte_i);
  assign match_init  = (CNT_W+1)'(mnib_q) + (CNT_W+1)'(MATCH_BASE_LEN);
  assign off_full    = {comp_byte_i, off_q[7:0]};
  assign lit_nib     = comp_byte_i[7:4];

  assign rd_addr_o = wp_q[AW-1:0] - off_q[AW-1:0];
  assign wr_addr_o = wp_q[AW-1:0];

  always_comb begin
    phase_d      = phase_q;
    wp_d         = wp_q;
    mnib_d       = mnib_q;
    lit_left_d   = lit_left_q;
    match_left_d = match_left_q;
    off_d        = off_q;
    fail         = 1'b0;
    lit_we_o     = 1'b0;
    res_o        = '0;
    res_o.status = ST_BYTE;
    res_o.count  = wp_q;

    if (opcode_i == OP_TICK) begin
      if (phase_q == PH_COPY) begin
        res_o.has_res = 1'b1;
        res_o.is_copy = 1'b1;
        res_o.count   = wp_q + CNT_W'(1);
        wp_d          = wp_q + CNT_W'(1);
        match_left_d  = match_left_q - CNT_W'(1);
        if (match_left_q == CNT_W'(1)) begin
          phase_d = PH_TOKEN;
        end
      end
    end else begin
      case (phase_q)
        PH_TOKEN: begin
          mnib_d = comp_byte_i[3:0];
          if (lit_nib == 4'd0) begin
            if (final_byte_i) begin
              phase_d       = PH_ENDED;
              res_o.has_res = 1'b1;
              res_o.status  = ST_DONE;
            end else begin
              phase_d = PH_OFF_LO;
            end
          end else if (final_byte_i || too_long(wp_q, (CNT_W+1)'(lit_nib))) begin
            fail = 1'b1;
          end else begin
            lit_left_d = CNT_W'(lit_nib);
            phase_d    = (lit_nib == NIBBLE_EXTENDED) ? PH_LIT_EXT : PH_LITERALS;
          end
        end
        PH_LIT_EXT: begin
          if (final_byte_i || too_long(wp_q, lit_total)) begin
            fail = 1'b1;
          end else begin
            lit_left_d = lit_total[CNT_W-1:0];
            if (comp_byte_i != LEN_EXT_CONTINUE) begin
              phase_d = PH_LITERALS;
            end
          end
        end
        PH_LITERALS: begin
          if (final_byte_i && (lit_left_q != CNT_W'(1))) begin
            fail = 1'b1;
          end else begin
            lit_we_o      = 1'b1;
            wp_d          = wp_q + CNT_W'(1);
            lit_left_d    = lit_left_q - CNT_W'(1);
            res_o.has_res = 1'b1;
            res_o.data    = comp_byte_i;
            res_o.count   = wp_q + CNT_W'(1);
            if (lit_left_q == CNT_W'(1)) begin
              if (final_byte_i) begin
                phase_d    = PH_ENDED;
                res_o.done = 1'b1;
              end else begin
                phase_d = PH_OFF_LO;
              end
            end
          end
        end
        PH_OFF_LO: begin
          if (final_byte_i) begin
            fail = 1'b1;
          end else begin
            off_d   = {8'd0, comp_byte_i};
            phase_d = PH_OFF_HI;
          end
        end
        PH_OFF_HI: begin
          off_d = off_full;
          if (final_byte_i || (off_full == 16'd0) || ({1'b0, off_full} > wp_q)) begin
            fail = 1'b1;
          end else if (too_long(wp_q, match_init)) begin
            fail = 1'b1;
          end else begin
            match_left_d = match_init[CNT_W-1:0];
            phase_d      = (mnib_q == NIBBLE_EXTENDED) ? PH_MATCH_EXT : PH_COPY;
          end
        end
        PH_MATCH_EXT: begin
          if (final_byte_i || too_long(wp_q, match_total)) begin
            fail = 1'b1;
          end else begin
            match_left_d = match_total[CNT_W-1:0];
            if (comp_byte_i != LEN_EXT_CONTINUE) begin
              phase_d = PH_COPY;
            end
          end
        end
        PH_COPY: begin
          // byte dropped, state untouched
          res_o.has_res = 1'b1;
          res_o.status  = ST_BUSY;
        end
        default: begin
          res_o.has_res = 1'b1;
          res_o.status  = ST_ERROR;
        end
      endcase
    end

    if (fail) begin
      phase_d       = PH_ENDED;
      res_o.has_res = 1'b1;
      res_o.status  = ST_ERROR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_TOKEN;
      wp_q         <= '0;
      mnib_q       <= '0;
      lit_left_q   <= '0;
      match_left_q <= '0;
      off_q        <= '0;
    end else if (accept_i) begin
      phase_q      <= phase_d;
      wp_q         <= wp_d;
      mnib_q       <= mnib_d;
      lit_left_q   <= lit_left_d;
      match_left_q <= match_left_d;
      off_q        <= off_d;
    end
  end

endmodule

// ----- design/lz4_block_decompressor_core.sv -----
// lz4 block decompressor: takes one compressed byte or copy tick per cycle (one transaction per
// clock when neither side stalls); results pass through a decode register and an output
// register; a copy byte is read from the history memory port with a registered read and
// written back as it leaves the decode register, with a bypass for offsets that reach the
// byte just copied; the history memory needs no clearing pass after reset
module lz4_block_decompressor_core
  import lz4d_pkg::*;
#(
  parameter int unsigned BLOCK_BYTES = BLOCK_BYTES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // input transaction channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              opcode_i,
  input  logic [7:0]        comp_byte_i,
  input  logic              final_byte_i,
  // result transaction channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        status_o,
  output logic [7:0]        out_byte_o,
  output logic              done_flag_o,
  output logic [CNT_W-1:0]  out_count_o
);

`include "lz4_block_decompressor_core_assert.svh"

  localparam int unsigned AW = $clog2(BLOCK_BYTES);

  // decoder interface
  logic          accept;
  dec_res_t      dec_res;
  logic [AW-1:0] dec_rd_addr;
  logic [AW-1:0] dec_wr_addr;
  logic          dec_lit_we;

  // decode register
  logic          s1_valid_q;
  dec_res_t      s1_res_q;
  logic [AW-1:0] s1_waddr_q;
  logic          s1_fwd_q;
  logic [7:0]    s1_fwd_byte_q;
  logic [7:0]    s1_byte;
  dec_res_t      s1_out;
  logic          s1_move;
  logic          s1_copy_wr;

  // output register
  logic          out_valid_q;
  dec_res_t      out_res_q;
  logic          out_free;

  // history memory
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic          mem_re;
  logic [7:0]    mem_rdata;

  // handshake: the decode register advances whenever the output register is free
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_move    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  lz4d_decoder #(
    .BLOCK_BYTES(BLOCK_BYTES),
    .AW         (AW)
  ) u_decoder (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .opcode_i    (opcode_i),
    .comp_byte_i (comp_byte_i),
    .final_byte_i(final_byte_i),
    .res_o       (dec_res),
    .rd_addr_o   (dec_rd_addr),
    .wr_addr_o   (dec_wr_addr),
    .lit_we_o    (dec_lit_we)
  );

  // copy byte: bypassed value when the read hit the byte written on the same edge
  assign s1_byte    = !s1_res_q.is_copy ? s1_res_q.data :
                      (s1_fwd_q ? s1_fwd_byte_q : mem_rdata);
  assign s1_copy_wr = s1_move && s1_res_q.is_copy;

  // result as it leaves the decode register, copy byte resolved
  always_comb begin
    s1_out      = s1_res_q;
    s1_out.data = s1_byte;
  end

  // one write port: copy write-back and literal writes never meet on the same edge
  assign mem_we    = s1_copy_wr || (accept && dec_lit_we);
  assign mem_waddr = s1_copy_wr ? s1_waddr_q : dec_wr_addr;
  assign mem_wdata = s1_copy_wr ? s1_byte : comp_byte_i;
  assign mem_re    = accept && dec_res.is_copy;

  lz4d_history #(
    .DEPTH(BLOCK_BYTES),
    .AW   (AW)
  ) u_history (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(dec_rd_addr),
    .rdata_o(mem_rdata)
  );

  // decode register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= dec_res.has_res;
    end else if (s1_move) begin
      s1_valid_q <= 1'b0;
    end
  end

  // decode register payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_res_q      <= dec_res;
      s1_waddr_q    <= dec_wr_addr;
      s1_fwd_q      <= s1_copy_wr && (dec_rd_addr == s1_waddr_q);
      s1_fwd_byte_q <= s1_byte;
    end
  end

  // output register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_move) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_res_q <= s1_out;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_res_q.status;
  assign out_byte_o  = out_res_q.data;
  assign done_flag_o = out_res_q.done;
  assign out_count_o = out_res_q.count;

  // a copy write-back and a literal write must never collide on the memory port
  `LZ4D_ASSERT_TOP(a_one_writer, !(s1_copy_wr && accept && dec_lit_we), "history write collision")
  // an accepted transaction with a result is held in the decode register next cycle
  `LZ4D_ASSERT_TOP(a_res_kept, accept && dec_res.has_res |=> s1_valid_q, "decoded result lost")
  // a stalled result in the decode register is not dropped
  `LZ4D_ASSERT_TOP(a_s1_hold, s1_valid_q && !out_free |=> s1_valid_q && $stable(s1_res_q),
                   "decode register changed while blocked")
  // a delivered byte always counts at least one produced byte
  `LZ4D_ASSERT_TOP(a_byte_count, out_valid_q && (out_res_q.status == ST_BYTE) |->
                   (out_res_q.count != '0), "byte result with zero count")

endmodule
